### rtl/ecbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecbt_pkg;

    // Table size and the widths that follow from it.
    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ACTIVE_W   = 5;
    localparam int LIM_W      = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    // Field widths of a transaction.
    localparam int DATA_W = 32;
    localparam int SLOT_W = 16;
    localparam int MODE_W = 2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);
    localparam logic [DATA_W-1:0]   HANDLE_TAG   = 32'hF100_0000;
    localparam logic [DATA_W-1:0]   NO_SLOT      = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0]   RET_ONE      = 32'd1;
    localparam logic [DATA_W-1:0]   RET_ZERO     = 32'd0;

    localparam logic [MODE_W-1:0] MODE_CALLBACK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NO_CALLBACK = 2'd1;

    typedef enum logic [2:0] {
        REQ_OPEN      = 3'd0,
        REQ_CLOSE     = 3'd1,
        REQ_ENABLE    = 3'd2,
        REQ_DISABLE   = 3'd3,
        REQ_DELIVER   = 3'd4,
        REQ_UNDELIVER = 3'd5,
        REQ_WAIT      = 3'd6,
        REQ_TEST      = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        SLOT_FREE      = 2'd0,
        SLOT_DISABLED  = 2'd1,
        SLOT_ENABLED   = 2'd2,
        SLOT_DELIVERED = 2'd3
    } slot_state_t;

    typedef enum logic [1:0] {
        KIND_RETURN   = 2'd0,
        KIND_RETRY    = 2'd1,
        KIND_CALLBACK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SCAN,
        CS_FINAL
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic single;
        logic scan;
        logic emit_final;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_scan;
        logic lim_zero;
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/ecbt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ecbt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ecbt_pkg::dp_status_t status,
    output ecbt_pkg::ctrl_cmd_t     cmd,
    output logic                    busy
);
    import ecbt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            CS_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                priority if (!status.is_scan)
                begin
                    cmd.single = 1'b1;
                    state_next = CS_IDLE;
                end
                else if (status.lim_zero)
                begin
                    state_next = CS_FINAL;
                end
                else
                begin
                    state_next = CS_SCAN;
                end
            end
            CS_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = CS_FINAL;
                end
            end
            CS_FINAL:
            begin
                cmd.emit_final = 1'b1;
                state_next     = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ecbt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ecbt_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ecbt_pkg::ctrl_cmd_t               cmd,
    output ecbt_pkg::dp_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [ecbt_pkg::ACTIVE_W-1:0]     cfg_wdata,
    input  wire logic [2:0]                        req_type,
    input  wire logic [ecbt_pkg::DATA_W-1:0]       event_class,
    input  wire logic [ecbt_pkg::DATA_W-1:0]       event_spec,
    input  wire logic [ecbt_pkg::MODE_W-1:0]       open_mode,
    input  wire logic [ecbt_pkg::DATA_W-1:0]       handler_addr,
    input  wire logic [ecbt_pkg::SLOT_W-1:0]       slot_id,
    output logic                                   result_valid,
    output logic [1:0]                             result_kind,
    output logic [ecbt_pkg::DATA_W-1:0]            return_value,
    output logic [ecbt_pkg::DATA_W-1:0]            callback_addr,
    output logic                                   last
);
    import ecbt_pkg::*;

    // Configuration and latched request.
    logic [ACTIVE_W-1:0] active_slots_reg;
    req_t                req_reg;
    logic [DATA_W-1:0]   class_reg;
    logic [DATA_W-1:0]   spec_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [DATA_W-1:0]   handler_reg;
    logic [SLOT_W-1:0]   slot_id_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;

    // Slot table: status is reset, the payload is only read once open has written it.
    slot_state_t         status_reg [SLOT_COUNT];
    slot_state_t         status_next [SLOT_COUNT];
    logic [DATA_W-1:0]   class_mem [SLOT_COUNT];
    logic [DATA_W-1:0]   spec_mem [SLOT_COUNT];
    logic [MODE_W-1:0]   mode_mem [SLOT_COUNT];
    logic [DATA_W-1:0]   handler_mem [SLOT_COUNT];

    // Result register.
    logic                valid_reg;
    logic                valid_next;
    logic [1:0]          kind_reg;
    logic [1:0]          kind_next;
    logic [DATA_W-1:0]   value_reg;
    logic [DATA_W-1:0]   value_next;
    logic [DATA_W-1:0]   cb_reg;
    logic [DATA_W-1:0]   cb_next;
    logic                last_reg;
    logic                last_next;

    logic [LIM_W-1:0]    lim;
    logic                slot_ok;
    logic [IDX_W-1:0]    rd_idx;
    slot_state_t         rd_status;
    logic [MODE_W-1:0]   rd_mode;
    logic                rd_match;
    logic                open_found;
    logic [IDX_W-1:0]    open_idx;
    logic                wr_en;

    assign lim = (LIM_W'(active_slots_reg) > LIM_W'(SLOT_COUNT)) ?
                 LIM_W'(SLOT_COUNT) : LIM_W'(active_slots_reg);
    assign slot_ok = slot_id_reg < SLOT_W'(lim);

    assign rd_idx    = cmd.scan ? idx_reg : slot_id_reg[IDX_W-1:0];
    assign rd_status = status_reg[rd_idx];
    assign rd_mode   = mode_mem[rd_idx];
    assign rd_match  = (class_mem[rd_idx] == class_reg) && (spec_mem[rd_idx] == spec_reg);

    assign status.is_scan   = (req_reg == REQ_DELIVER) || (req_reg == REQ_UNDELIVER);
    assign status.lim_zero  = (lim == '0);
    assign status.scan_last = ((LIM_W'(idx_reg) + LIM_W'(1)) == lim);

    // Lowest free slot below the limit.
    always_comb
    begin
        open_found = 1'b0;
        open_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if ((status_reg[i] == SLOT_FREE) && (LIM_W'(i) < lim))
            begin
                open_found = 1'b1;
                open_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        status_next = status_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;
        valid_next  = 1'b0;
        kind_next   = kind_reg;
        value_next  = value_reg;
        cb_next     = cb_reg;
        last_next   = last_reg;

        if (cmd.load)
        begin
            idx_next = '0;
        end

        if (cmd.single)
        begin
            valid_next = 1'b1;
            kind_next  = KIND_RETURN;
            value_next = RET_ZERO;
            cb_next    = '0;
            last_next  = 1'b1;
            unique case (req_reg)
                REQ_OPEN:
                begin
                    if (open_found)
                    begin
                        status_next[open_idx] = SLOT_DISABLED;
                        wr_en                 = 1'b1;
                        value_next            = HANDLE_TAG | DATA_W'(open_idx);
                    end
                    else
                    begin
                        value_next = NO_SLOT;
                    end
                end
                REQ_CLOSE, REQ_ENABLE, REQ_DISABLE:
                begin
                    value_next = RET_ONE;
                    if (slot_ok && (rd_status != SLOT_FREE))
                    begin
                        unique case (req_reg)
                            REQ_CLOSE:  status_next[rd_idx] = SLOT_FREE;
                            REQ_ENABLE: status_next[rd_idx] = SLOT_ENABLED;
                            default:    status_next[rd_idx] = SLOT_DISABLED;
                        endcase
                    end
                end
                REQ_WAIT, REQ_TEST:
                begin
                    priority if (!slot_ok)
                    begin
                        value_next = RET_ZERO;
                    end
                    else if (rd_status == SLOT_DELIVERED)
                    begin
                        value_next = RET_ONE;
                        if (rd_mode == MODE_NO_CALLBACK)
                        begin
                            status_next[rd_idx] = SLOT_ENABLED;
                        end
                    end
                    else if ((rd_status == SLOT_ENABLED) && (req_reg == REQ_WAIT))
                    begin
                        kind_next = KIND_RETRY;
                    end
                    else
                    begin
                        value_next = RET_ZERO;
                    end
                end
                default:
                begin
                    // Deliver and undeliver go through the scan instead.
                    valid_next = 1'b0;
                end
            endcase
        end

        if (cmd.scan)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (req_reg == REQ_DELIVER)
            begin
                if ((rd_status == SLOT_ENABLED) && rd_match)
                begin
                    if (rd_mode == MODE_CALLBACK)
                    begin
                        valid_next = 1'b1;
                        kind_next  = KIND_CALLBACK;
                        value_next = RET_ZERO;
                        cb_next    = handler_mem[rd_idx];
                        last_next  = 1'b0;
                    end
                    else
                    begin
                        status_next[rd_idx] = SLOT_DELIVERED;
                    end
                end
            end
            else if ((rd_status == SLOT_DELIVERED) && rd_match &&
                     (rd_mode == MODE_NO_CALLBACK))
            begin
                status_next[rd_idx] = SLOT_ENABLED;
            end
        end

        if (cmd.emit_final)
        begin
            valid_next = 1'b1;
            kind_next  = KIND_RETURN;
            value_next = RET_ZERO;
            cb_next    = '0;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg <= ACTIVE_RESET;
            idx_reg          <= '0;
            valid_reg        <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                status_reg[i] <= SLOT_FREE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                active_slots_reg <= cfg_wdata;
            end
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req_t'(req_type);
            class_reg   <= event_class;
            spec_reg    <= event_spec;
            mode_reg    <= open_mode;
            handler_reg <= handler_addr;
            slot_id_reg <= slot_id;
        end
        if (wr_en)
        begin
            class_mem[open_idx]   <= class_reg;
            spec_mem[open_idx]    <= spec_reg;
            mode_mem[open_idx]    <= mode_reg;
            handler_mem[open_idx] <= handler_reg;
        end
        kind_reg  <= kind_next;
        value_reg <= value_next;
        cb_reg    <= cb_next;
        last_reg  <= last_next;
    end

    assign result_valid  = valid_reg;
    assign result_kind   = kind_reg;
    assign return_value  = value_reg;
    assign callback_addr = cb_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

### rtl/event_control_block_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Open, close, enable, disable, wait and test: the request is latched, the table is updated in
// the execute state and the result strobe is registered from it; a new transaction may be
// taken as that result is shown. Deliver and undeliver visit one slot per cycle through the
// single table read port, up to the slot limit (active_slots clamped to the table size), then
// give the closing result. Results cannot be stalled. Reset is asynchronous and active low:
// it marks every slot free, sets active_slots to 16 and needs no clearing pass.

module event_control_block_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cfg_we,
    input  wire logic [ecbt_pkg::ACTIVE_W-1:0] cfg_wdata,
    input  wire logic [2:0]                    req_type,
    input  wire logic [ecbt_pkg::DATA_W-1:0]   event_class,
    input  wire logic [ecbt_pkg::DATA_W-1:0]   event_spec,
    input  wire logic [ecbt_pkg::MODE_W-1:0]   open_mode,
    input  wire logic [ecbt_pkg::DATA_W-1:0]   handler_addr,
    input  wire logic [ecbt_pkg::SLOT_W-1:0]   slot_id,
    output logic                               result_valid,
    output logic [1:0]                         result_kind,
    output logic [ecbt_pkg::DATA_W-1:0]        return_value,
    output logic [ecbt_pkg::DATA_W-1:0]        callback_addr,
    output logic                               last
);
    import ecbt_pkg::*;

    // The controller sequences each transaction: it latches the request, then either runs
    // a single table update or steps through the slots for deliver and undeliver, finishing
    // with the closing result. The datapath holds the slot table, the scan index and the
    // result register, and reports back whether a scan is needed and when it ends.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    ecbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The result register is loaded only by the controller's commands, so the final result
    // of a transaction appears in the same cycle as busy falls and the next transaction may
    // be accepted in that cycle.
    ecbt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_type      (req_type),
        .event_class   (event_class),
        .event_spec    (event_spec),
        .open_mode     (open_mode),
        .handler_addr  (handler_addr),
        .slot_id       (slot_id),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .return_value  (return_value),
        .callback_addr (callback_addr),
        .last          (last)
    );

endmodule

`default_nettype wire

### rtl/ecbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ecbt_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        result_valid,
    input  wire logic [1:0]                  result_kind,
    input  wire logic [ecbt_pkg::DATA_W-1:0] callback_addr,
    input  wire logic                        last
);
    import ecbt_pkg::*;

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // Busy only falls as the final result of a transaction is shown.
    a_fall_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last)
        else $error("busy fell without a final result");

    // Intermediate results only occur while the transaction is still in progress.
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("intermediate result while idle");

    // Callback requests are never final; every other result is final with no handler.
    a_callback_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_CALLBACK) |-> !last)
        else $error("callback request marked final");

    a_other_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind != KIND_CALLBACK) |-> last && (callback_addr == '0))
        else $error("non-callback result not final or carries a handler");

endmodule

bind event_control_block_table ecbt_checker u_ecbt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .callback_addr (callback_addr),
    .last          (last)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

// Testbench for the event control block table.
//
// A short scripted sequence comes first, then several phases of random transactions, each
// under a different active_slots setting. Every accepted transaction is run through a
// behavioural copy of the slot table kept here in the bench. That copy appends the replies
// it expects to a queue, and each result strobe from the block is checked against the oldest
// entry in that queue.
module tb;

    import ecbt_pkg::*;

    // Mode values that are neither callback nor no-callback are stored as given.
    localparam logic [MODE_W-1:0] MODE_OTHER_A = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OTHER_B = 2'd3;

    localparam int PHASE_ITEMS    = 51;
    localparam int WATCHDOG_LIMIT = 400;

    typedef struct {
        req_t                op;
        logic [DATA_W-1:0]   cls;
        logic [DATA_W-1:0]   spec;
        logic [MODE_W-1:0]   mode;
        logic [DATA_W-1:0]   handler;
        logic [SLOT_W-1:0]   slot;
    } request_t;

    typedef struct {
        kind_t               kind;
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   callback;
        logic                last;
    } reply_t;

    // One row of the scripted sequence. Where typed is set, the row carries its own
    // single reply, which can be read straight off the table's behaviour.
    typedef struct {
        req_t                op;
        logic [DATA_W-1:0]   cls;
        logic [DATA_W-1:0]   spec;
        logic [MODE_W-1:0]   mode;
        logic [DATA_W-1:0]   handler;
        logic [SLOT_W-1:0]   slot;
        bit                  typed;
        kind_t               kind;
        logic [DATA_W-1:0]   value;
    } script_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic                cfg_we       = 1'b0;
    logic [ACTIVE_W-1:0] cfg_wdata    = '0;
    logic [2:0]          req_type     = REQ_OPEN;
    logic [DATA_W-1:0]   event_class  = '0;
    logic [DATA_W-1:0]   event_spec   = '0;
    logic [MODE_W-1:0]   open_mode    = MODE_CALLBACK;
    logic [DATA_W-1:0]   handler_addr = '0;
    logic [SLOT_W-1:0]   slot_id      = '0;
    logic                result_valid;
    logic [1:0]          result_kind;
    logic [DATA_W-1:0]   return_value;
    logic [DATA_W-1:0]   callback_addr;
    logic                last;

    event_control_block_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_type      (req_type),
        .event_class   (event_class),
        .event_spec    (event_spec),
        .open_mode     (open_mode),
        .handler_addr  (handler_addr),
        .slot_id       (slot_id),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .return_value  (return_value),
        .callback_addr (callback_addr),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bench copy of the slot table and of the active slot limit (already clamped).
    slot_state_t       tbl_state   [SLOT_COUNT];
    logic [DATA_W-1:0] tbl_class   [SLOT_COUNT];
    logic [DATA_W-1:0] tbl_spec    [SLOT_COUNT];
    logic [MODE_W-1:0] tbl_mode    [SLOT_COUNT];
    logic [DATA_W-1:0] tbl_handler [SLOT_COUNT];
    int                slot_limit  = SLOT_COUNT;

    reply_t awaited_replies [$];
    reply_t fresh_replies   [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;

    // Class and spec pairs that random transactions mostly draw from, so that deliver and
    // undeliver find matching slots often enough to be interesting.
    logic [DATA_W-1:0] class_pool [3] = '{32'h0000_0010, 32'h8000_0001, 32'h0000_0010};
    logic [DATA_W-1:0] spec_pool  [3] = '{32'h0000_0020, 32'h7FFF_FFFE, 32'h0000_0021};

    // Settings applied before each random phase: two values that get clamped, the single slot,
    // the empty table, the exact table size and one ordinary value.
    logic [ACTIVE_W-1:0] phase_limits [6] = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd6, 5'd20};

    script_row_t script [25] = '{
        // A fresh table: a free slot, an out-of-range slot and a close of nothing.
        '{REQ_WAIT,      '0, '0, MODE_CALLBACK,    '0,      16'd0,  1'b1, KIND_RETURN, RET_ZERO},
        '{REQ_TEST,      '0, '0, MODE_CALLBACK,    '0,      '1,     1'b1, KIND_RETURN, RET_ZERO},
        '{REQ_CLOSE,     '0, '0, MODE_CALLBACK,    '0,      '1,     1'b1, KIND_RETURN, RET_ONE},
        // Four opens take slots 0 to 3: two in callback mode, one no-callback, one other-mode.
        '{REQ_OPEN,      '1, '1, MODE_CALLBACK,    '1,      16'd0,  1'b1, KIND_RETURN,
          32'hF100_0000},
        '{REQ_OPEN,      '0, '0, MODE_NO_CALLBACK, '0,      16'd0,  1'b1, KIND_RETURN,
          32'hF100_0001},
        '{REQ_OPEN,      '0, '0, MODE_OTHER_A,     32'h1234_5678, 16'd0, 1'b1, KIND_RETURN,
          32'hF100_0002},
        '{REQ_OPEN, 32'hA5A5_A5A5, 32'h5A5A_5A5A, MODE_CALLBACK, 32'hDEAD_BEEF, 16'd0, 1'b1,
          KIND_RETURN, 32'hF100_0003},
        '{REQ_ENABLE,    '0, '0, MODE_CALLBACK,    '0,      16'd0,  1'b1, KIND_RETURN, RET_ONE},
        '{REQ_ENABLE,    '0, '0, MODE_CALLBACK,    '0,      16'd1,  1'b1, KIND_RETURN, RET_ONE},
        '{REQ_ENABLE,    '0, '0, MODE_CALLBACK,    '0,      16'd2,  1'b1, KIND_RETURN, RET_ONE},
        '{REQ_ENABLE,    '0, '0, MODE_CALLBACK,    '0,      16'd3,  1'b1, KIND_RETURN, RET_ONE},
        // A callback for slot 0, then the no-callback and other-mode slots get delivered.
        '{REQ_DELIVER,   '1, '1, MODE_CALLBACK,    '0,      16'd0,  1'b0, KIND_RETURN, RET_ZERO},
        '{REQ_WAIT,      '0, '0, MODE_CALLBACK,    '0,      16'd1,  1'b1, KIND_RETRY,  RET_ZERO},
        '{REQ_DELIVER,   '0, '0, MODE_CALLBACK,    '0,      16'd0,  1'b0, KIND_RETURN, RET_ZERO},
        '{REQ_TEST,      '0, '0, MODE_CALLBACK,    '0,      16'd2,  1'b1, KIND_RETURN, RET_ONE},
        // Undeliver re-arms only the no-callback slot; the other-mode slot stays delivered.
        '{REQ_UNDELIVER, '0, '0, MODE_CALLBACK,    '0,      16'd0,  1'b0, KIND_RETURN, RET_ZERO},
        '{REQ_WAIT,      '0, '0, MODE_CALLBACK,    '0,      16'd1,  1'b1, KIND_RETRY,  RET_ZERO},
        '{REQ_DELIVER,   '0, '0, MODE_CALLBACK,    '0,      16'd0,  1'b0, KIND_RETURN, RET_ZERO},
        '{REQ_WAIT,      '0, '0, MODE_CALLBACK,    '0,      16'd1,  1'b1, KIND_RETURN, RET_ONE},
        // A disabled slot is passed over by deliver and reads as not ready.
        '{REQ_DISABLE,   '0, '0, MODE_CALLBACK,    '0,      16'd3,  1'b1, KIND_RETURN, RET_ONE},
        '{REQ_DELIVER, 32'hA5A5_A5A5, 32'h5A5A_5A5A, MODE_CALLBACK, '0, 16'd0, 1'b0,
          KIND_RETURN, RET_ZERO},
        // A closed slot is the first one that the next open finds.
        '{REQ_CLOSE,     '0, '0, MODE_CALLBACK,    '0,      16'd0,  1'b1, KIND_RETURN, RET_ONE},
        '{REQ_OPEN, 32'h0000_0001, 32'h0000_0002, MODE_OTHER_B, 32'h8000_0000, 16'd0, 1'b1,
          KIND_RETURN, 32'hF100_0000},
        '{REQ_TEST,      '0, '0, MODE_CALLBACK,    '0,      16'd3,  1'b1, KIND_RETURN, RET_ZERO},
        '{REQ_WAIT,      '0, '0, MODE_CALLBACK,    '0,      16'd15, 1'b1, KIND_RETURN, RET_ZERO}
    };

    function automatic void add_reply(kind_t kind, logic [DATA_W-1:0] value,
                                      logic [DATA_W-1:0] callback, logic is_last);
        reply_t rep;
        rep.kind     = kind;
        rep.value    = value;
        rep.callback = callback;
        rep.last     = is_last;
        fresh_replies.push_back(rep);
    endfunction

    // Applies one transaction to the bench table and leaves the replies it causes in
    // fresh_replies, in the order the block must produce them.
    function automatic void serve_request(request_t r);
        bit in_range;
        bit found;
        fresh_replies.delete();
        in_range = (int'(r.slot) < slot_limit);
        found    = 1'b0;
        case (r.op)
            REQ_OPEN:
            begin
                for (int i = 0; i < slot_limit; i++)
                begin
                    if (!found && tbl_state[i] == SLOT_FREE)
                    begin
                        found          = 1'b1;
                        tbl_state[i]   = SLOT_DISABLED;
                        tbl_class[i]   = r.cls;
                        tbl_spec[i]    = r.spec;
                        tbl_mode[i]    = r.mode;
                        tbl_handler[i] = r.handler;
                        add_reply(KIND_RETURN, HANDLE_TAG | DATA_W'(i), '0, 1'b1);
                    end
                end
                if (!found)
                begin
                    add_reply(KIND_RETURN, NO_SLOT, '0, 1'b1);
                end
            end
            REQ_CLOSE, REQ_ENABLE, REQ_DISABLE:
            begin
                if (in_range && tbl_state[r.slot] != SLOT_FREE)
                begin
                    tbl_state[r.slot] = (r.op == REQ_CLOSE)  ? SLOT_FREE :
                                        (r.op == REQ_ENABLE) ? SLOT_ENABLED : SLOT_DISABLED;
                end
                add_reply(KIND_RETURN, RET_ONE, '0, 1'b1);
            end
            REQ_DELIVER:
            begin
                for (int i = 0; i < slot_limit; i++)
                begin
                    if (tbl_state[i] == SLOT_ENABLED && tbl_class[i] == r.cls &&
                        tbl_spec[i] == r.spec)
                    begin
                        if (tbl_mode[i] == MODE_CALLBACK)
                        begin
                            add_reply(KIND_CALLBACK, RET_ZERO, tbl_handler[i], 1'b0);
                        end
                        else
                        begin
                            tbl_state[i] = SLOT_DELIVERED;
                        end
                    end
                end
                add_reply(KIND_RETURN, RET_ZERO, '0, 1'b1);
            end
            REQ_UNDELIVER:
            begin
                for (int i = 0; i < slot_limit; i++)
                begin
                    if (tbl_state[i] == SLOT_DELIVERED && tbl_class[i] == r.cls &&
                        tbl_spec[i] == r.spec && tbl_mode[i] == MODE_NO_CALLBACK)
                    begin
                        tbl_state[i] = SLOT_ENABLED;
                    end
                end
                add_reply(KIND_RETURN, RET_ZERO, '0, 1'b1);
            end
            default:
            begin
                // Wait and test share everything but the not-ready reply.
                if (!in_range)
                begin
                    add_reply(KIND_RETURN, RET_ZERO, '0, 1'b1);
                end
                else if (tbl_state[r.slot] == SLOT_DELIVERED)
                begin
                    if (tbl_mode[r.slot] == MODE_NO_CALLBACK)
                    begin
                        tbl_state[r.slot] = SLOT_ENABLED;
                    end
                    add_reply(KIND_RETURN, RET_ONE, '0, 1'b1);
                end
                else if (tbl_state[r.slot] == SLOT_ENABLED && r.op == REQ_WAIT)
                begin
                    add_reply(KIND_RETRY, RET_ZERO, '0, 1'b1);
                end
                else
                begin
                    add_reply(KIND_RETURN, RET_ZERO, '0, 1'b1);
                end
            end
        endcase
    endfunction

    // Random transactions are weighted towards opens, enables and delivers, with slot
    // numbers mostly near the table and class/spec pairs mostly from the shared pool, so
    // that slots move through their whole life cycle. The rest is out-of-range noise.
    function automatic request_t random_request();
        request_t r;
        int       roll;
        int       pick;
        roll = $urandom_range(0, 99);
        if      (roll < 22) r.op = REQ_OPEN;
        else if (roll < 30) r.op = REQ_CLOSE;
        else if (roll < 50) r.op = REQ_ENABLE;
        else if (roll < 56) r.op = REQ_DISABLE;
        else if (roll < 72) r.op = REQ_DELIVER;
        else if (roll < 80) r.op = REQ_UNDELIVER;
        else if (roll < 90) r.op = REQ_WAIT;
        else                r.op = REQ_TEST;

        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 2);
        if (roll < 85)
        begin
            r.cls  = class_pool[pick];
            r.spec = spec_pool[pick];
        end
        else
        begin
            r.cls  = $urandom;
            r.spec = $urandom;
        end

        roll = $urandom_range(0, 99);
        if      (roll < 45) r.mode = MODE_CALLBACK;
        else if (roll < 85) r.mode = MODE_NO_CALLBACK;
        else if (roll < 93) r.mode = MODE_OTHER_A;
        else                r.mode = MODE_OTHER_B;

        r.handler = $urandom;

        roll = $urandom_range(0, 99);
        if      (roll < 80) r.slot = SLOT_W'($urandom_range(0, SLOT_COUNT));
        else if (roll < 90) r.slot = SLOT_W'(slot_limit);
        else                r.slot = SLOT_W'($urandom_range(0, 65535));
        return r;
    endfunction

    // Presents one transaction from the falling edge and holds it until the block takes it.
    // With idling on, the sender first lets the block finish the previous transaction and
    // then may idle for a few cycles, one cycle at a time, so that the idle cycles are ones
    // in which the block could have taken a transaction.
    task automatic issue(request_t r, bit typed, kind_t kind, logic [DATA_W-1:0] value);
        @(negedge clk);
        if (gaps_on)
        begin
            while (busy)
            begin
                @(negedge clk);
            end
            while ($urandom_range(0, 99) < 38)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start        <= 1'b1;
        req_type     <= r.op;
        event_class  <= r.cls;
        event_spec   <= r.spec;
        open_mode    <= r.mode;
        handler_addr <= r.handler;
        slot_id      <= r.slot;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        // Accepted at this edge: the bench table advances in step with the block.
        serve_request(r);
        if (typed)
        begin
            awaited_replies.push_back(reply_t'{kind, value, '0, 1'b1});
        end
        else
        begin
            foreach (fresh_replies[k])
            begin
                awaited_replies.push_back(fresh_replies[k]);
            end
        end
    endtask

    // Drops start and lets every outstanding transaction finish before the caller moves on.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The register is only written while the block is idle.
    task automatic set_active_slots(logic [ACTIVE_W-1:0] value);
        drain();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        slot_limit = (int'(value) > SLOT_COUNT) ? SLOT_COUNT : int'(value);
    endtask

    // Result checking. Each strobe is one result transaction, taken at this edge.
    always @(posedge clk)
    begin
        reply_t due;
        if (rst_n && result_valid)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result with nothing outstanding: kind %0d value %h callback %h",
                       result_kind, return_value, callback_addr);
                mismatches = mismatches + 1;
            end
            else
            begin
                due = awaited_replies[0];
                awaited_replies.delete(0);
                if (result_kind !== due.kind)
                begin
                    $error("result_kind expected %0d got %0d", due.kind, result_kind);
                    mismatches = mismatches + 1;
                end
                if (return_value !== due.value)
                begin
                    $error("return_value expected %h got %h", due.value, return_value);
                    mismatches = mismatches + 1;
                end
                if (callback_addr !== due.callback)
                begin
                    $error("callback_addr expected %h got %h", due.callback, callback_addr);
                    mismatches = mismatches + 1;
                end
                if (last !== due.last)
                begin
                    $error("last expected %0d got %0d", due.last, last);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Watchdog: the run is abandoned after a long stretch in which the block neither takes
    // a transaction nor produces a result.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        request_t rq;

        foreach (tbl_state[i])
        begin
            tbl_state[i]   = SLOT_FREE;
            tbl_class[i]   = '0;
            tbl_spec[i]    = '0;
            tbl_mode[i]    = MODE_CALLBACK;
            tbl_handler[i] = '0;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Scripted part, at the reset setting of 16 slots.
        foreach (script[n])
        begin
            rq.op      = script[n].op;
            rq.cls     = script[n].cls;
            rq.spec    = script[n].spec;
            rq.mode    = script[n].mode;
            rq.handler = script[n].handler;
            rq.slot    = script[n].slot;
            issue(rq, script[n].typed, script[n].kind, script[n].value);
        end

        // Random phases. The fourth runs without any idling from the sender.
        foreach (phase_limits[p])
        begin
            set_active_slots(phase_limits[p]);
            gaps_on = (p != 3);
            repeat (PHASE_ITEMS)
            begin
                issue(random_request(), 1'b0, KIND_RETURN, RET_ZERO);
            end
        end

        drain();
        repeat (2 * SLOT_COUNT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
